// ===== rtl/gha_pkg.sv =====
package gha_pkg;

  localparam int IDX_W    = 10;
  localparam int CAPACITY = 1 << IDX_W;
  localparam int VER_W    = 12;
  localparam int CNT_W    = IDX_W + 1;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE      = 3'd0,
    OP_DESTROY     = 3'd1,
    OP_IS_VALID    = 3'd2,
    OP_WAS_REMOVED = 3'd3,
    OP_GET_VERSION = 3'd4
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e           op;
    logic [IDX_W-1:0]  idx;
    logic [VER_W-1:0]  ver;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [VER_W-1:0]  ver;
    logic              answer;
    status_e           status;
  } res_t;

  typedef struct packed {
    logic accept;
    logic fire;
  } ctl_t;

endpackage

// ===== rtl/generational_handle_allocator.sv =====
// Generational handle allocator: hands out handles of a 10-bit index and a
// 12-bit version, reusing freed indices last-in first-out. Each word passes an
// input register, where the version table is read, and a result register; a
// word is taken every cycle when the output is not stalled. A create that
// follows directly behind a create or a destroy is held until that word has
// left the input register, as the popped index must come off the free-index
// memory before its version can be read; every other sequence runs at one
// word per cycle unless the output stalls. No clearing pass follows reset.
module generational_handle_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gha_pkg::OP_W-1:0]   opcode_i,
  input  logic [gha_pkg::IDX_W-1:0]  handle_index_i,
  input  logic [gha_pkg::VER_W-1:0]  handle_version_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gha_pkg::IDX_W-1:0]  result_index_o,
  output logic [gha_pkg::VER_W-1:0]  result_version_o,
  output logic                       answer_o,
  output logic [gha_pkg::ST_W-1:0]   status_o
);
  import gha_pkg::*;

  req_t  in_req;
  req_t  s_req_q;
  logic  s_valid_q;
  res_t  res;
  res_t  out_res_q;
  logic  out_valid_q;
  logic  out_ready;
  logic  hazard;
  ctl_t  ctl;

  assign in_req    = '{op: opcode_e'(opcode_i), idx: handle_index_i, ver: handle_version_i};
  assign out_ready = !out_valid_q || !out_stall_i;
  assign hazard    = s_valid_q && (in_req.op == OP_CREATE) &&
                     (s_req_q.op == OP_CREATE || s_req_q.op == OP_DESTROY);
  assign in_stall_o = (s_valid_q && !out_ready) || hazard;
  assign ctl.accept = in_valid_i && !in_stall_o;
  assign ctl.fire   = s_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl.accept) begin
        s_valid_q <= 1'b1;
      end else if (ctl.fire) begin
        s_valid_q <= 1'b0;
      end
      if (ctl.fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      s_req_q <= in_req;
    end
    if (ctl.fire) begin
      out_res_q <= res;
    end
  end

  gha_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .in_req_i (in_req),
    .s_req_i  (s_req_q),
    .res_o    (res)
  );

  assign out_valid_o      = out_valid_q;
  assign result_index_o   = out_res_q.idx;
  assign result_version_o = out_res_q.ver;
  assign answer_o         = out_res_q.answer;
  assign status_o         = out_res_q.status;

endmodule

// ===== rtl/gha_ram.sv =====
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gha_exec.sv =====
module gha_exec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gha_pkg::ctl_t ctl_i,
  input  gha_pkg::req_t in_req_i,
  input  gha_pkg::req_t s_req_i,
  output gha_pkg::res_t res_o
);
  import gha_pkg::*;

  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] fc_q, fc_d;

  logic             vt_we;
  logic [IDX_W-1:0] vt_waddr;
  logic [VER_W-1:0] vt_wdata;
  logic [IDX_W-1:0] vt_raddr;
  logic [VER_W-1:0] vt_rdata;
  logic             vbyp_q;
  logic [VER_W-1:0] vbyp_data_q;

  logic             fs_we;
  logic [IDX_W-1:0] fs_waddr;
  logic [IDX_W-1:0] fs_raddr;
  logic [IDX_W-1:0] fs_rdata;
  logic             sbyp_q;
  logic [IDX_W-1:0] sbyp_data_q;

  logic [IDX_W-1:0] top_now;
  logic [VER_W-1:0] stored_raw;
  logic [VER_W-1:0] stored;
  logic [VER_W-1:0] bumped;
  logic             alloc;
  logic             do_push, do_pop, do_append, do_bump;
  res_t             res;

  assign top_now    = sbyp_q ? sbyp_data_q : fs_rdata;
  assign stored_raw = vbyp_q ? vbyp_data_q : vt_rdata;
  assign alloc      = {1'b0, s_req_i.idx} < used_q;
  assign stored     = alloc ? stored_raw : '0;
  assign bumped     = stored_raw + VER_W'(1);

  always_comb begin
    res       = '{idx: s_req_i.idx, ver: stored, answer: 1'b0, status: ST_OK};
    do_push   = 1'b0;
    do_pop    = 1'b0;
    do_append = 1'b0;
    do_bump   = 1'b0;
    case (s_req_i.op)
      OP_CREATE: begin
        if (fc_q != '0) begin
          do_pop = 1'b1;
          res    = '{idx: top_now, ver: stored_raw, answer: 1'b0, status: ST_OK};
        end else if (used_q < CNT_W'(CAPACITY)) begin
          do_append = 1'b1;
          res       = '{idx: used_q[IDX_W-1:0], ver: '0, answer: 1'b0, status: ST_OK};
        end else begin
          res = '{idx: '0, ver: '0, answer: 1'b0, status: ST_FULL};
        end
      end
      OP_DESTROY: begin
        if (alloc && stored_raw == s_req_i.ver) begin
          do_bump    = 1'b1;
          do_push    = fc_q < CNT_W'(CAPACITY);
          res.ver    = bumped;
          res.answer = 1'b1;
        end
      end
      OP_IS_VALID:    res.answer = stored_raw == s_req_i.ver;
      OP_WAS_REMOVED: res.answer = stored_raw > s_req_i.ver;
      OP_GET_VERSION: res.answer = 1'b1;
      default: begin
        res = '{idx: '0, ver: '0, answer: 1'b0, status: ST_OK};
      end
    endcase
    if (!alloc && (s_req_i.op == OP_DESTROY || s_req_i.op == OP_IS_VALID ||
                   s_req_i.op == OP_WAS_REMOVED || s_req_i.op == OP_GET_VERSION)) begin
      res        = '{idx: s_req_i.idx, ver: '0, answer: 1'b0, status: ST_NOT_ALLOC};
      do_push    = 1'b0;
      do_bump    = 1'b0;
    end
  end

  assign res_o = res;

  assign vt_we    = ctl_i.fire && (do_append || do_bump);
  assign vt_waddr = do_append ? used_q[IDX_W-1:0] : s_req_i.idx;
  assign vt_wdata = do_append ? '0 : bumped;
  assign vt_raddr = (in_req_i.op == OP_CREATE) ? top_now : in_req_i.idx;

  assign fs_we    = ctl_i.fire && do_push;
  assign fs_waddr = fc_q[IDX_W-1:0];

  always_comb begin
    fc_d   = fc_q;
    used_d = used_q;
    if (ctl_i.fire) begin
      if (do_push) begin
        fc_d = fc_q + CNT_W'(1);
      end
      if (do_pop) begin
        fc_d = fc_q - CNT_W'(1);
      end
      if (do_append) begin
        used_d = used_q + CNT_W'(1);
      end
    end
  end

  assign fs_raddr = IDX_W'(fc_d - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      fc_q   <= '0;
      sbyp_q <= 1'b0;
      vbyp_q <= 1'b0;
    end else begin
      used_q <= used_d;
      fc_q   <= fc_d;
      sbyp_q <= fs_we && (fs_waddr == fs_raddr);
      if (ctl_i.accept) begin
        vbyp_q <= vt_we && (vt_waddr == vt_raddr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sbyp_data_q <= s_req_i.idx;
    if (ctl_i.accept) begin
      vbyp_data_q <= vt_wdata;
    end
  end

  gha_ram #(
    .WIDTH (VER_W),
    .DEPTH (CAPACITY)
  ) u_version_ram (
    .clk_i   (clk_i),
    .we_i    (vt_we),
    .waddr_i (vt_waddr),
    .wdata_i (vt_wdata),
    .re_i    (ctl_i.accept),
    .raddr_i (vt_raddr),
    .rdata_o (vt_rdata)
  );

  gha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (s_req_i.idx),
    .re_i    (1'b1),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

endmodule

// ===== rtl/gha_checker.sv =====
module gha_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [gha_pkg::OP_W-1:0]   opcode_i,
  input logic [gha_pkg::IDX_W-1:0]  handle_index_i,
  input logic [gha_pkg::VER_W-1:0]  handle_version_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [gha_pkg::IDX_W-1:0]  result_index_o,
  input logic [gha_pkg::VER_W-1:0]  result_version_o,
  input logic                       answer_o,
  input logic [gha_pkg::ST_W-1:0]   status_o
);
  import gha_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(opcode_i) &&
      $stable(handle_index_i) && $stable(handle_version_i))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_index_o) &&
      $stable(result_version_o) && $stable(answer_o) && $stable(status_o))
    else $error("stalled result word changed");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |->
      result_index_o == '0 && result_version_o == '0 && !answer_o)
    else $error("full result carries a handle");

  a_unalloc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NOT_ALLOC |-> result_version_o == '0 && !answer_o)
    else $error("unallocated index reports a version");

  a_answer_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && answer_o |-> status_o == ST_OK)
    else $error("positive answer with error status");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import gha_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;
  localparam int TAIL_CYCLES = 8;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode;
  logic [IDX_W-1:0]  handle_index;
  logic [VER_W-1:0]  handle_version;
  logic              out_valid_o;
  logic              out_stall;
  logic [IDX_W-1:0]  result_index_o;
  logic [VER_W-1:0]  result_version_o;
  logic              answer_o;
  logic [ST_W-1:0]   status_o;

  bit [VER_W-1:0]  ver_table [CAPACITY];
  bit [IDX_W-1:0]  free_idx [CAPACITY];
  int              n_used;
  int              n_free;
  res_t            handle_results_due [$];
  res_t            oldest_due;
  int              mismatches;
  bit              steady;

  generational_handle_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode),
    .handle_index_i   (handle_index),
    .handle_version_i (handle_version),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .result_index_o   (result_index_o),
    .result_version_o (result_version_o),
    .answer_o         (answer_o),
    .status_o         (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic res_t apply_handle_op(input logic [OP_W-1:0] op,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [VER_W-1:0] ver);
    res_t            r;
    bit              live;
    bit [VER_W-1:0]  stored;
    bit [IDX_W-1:0]  k;
    live   = idx < n_used;
    stored = live ? ver_table[idx] : '0;
    r.idx    = idx;
    r.ver    = stored;
    r.answer = 1'b0;
    r.status = live ? ST_OK : ST_NOT_ALLOC;
    case (op)
      OP_CREATE: begin
        if (n_free > 0) begin
          n_free--;
          k = free_idx[IDX_W'(n_free)];
          r.idx    = k;
          r.ver    = ver_table[k];
          r.status = ST_OK;
        end else if (n_used < CAPACITY) begin
          ver_table[IDX_W'(n_used)] = '0;
          r.idx    = IDX_W'(n_used);
          r.ver    = '0;
          r.status = ST_OK;
          n_used++;
        end else begin
          r.idx    = '0;
          r.ver    = '0;
          r.status = ST_FULL;
        end
      end
      OP_DESTROY: begin
        if (live && stored == ver) begin
          ver_table[idx] = stored + 1'b1;
          if (n_free < CAPACITY) begin
            free_idx[IDX_W'(n_free)] = idx;
            n_free++;
          end
          r.ver    = ver_table[idx];
          r.answer = 1'b1;
        end
      end
      OP_IS_VALID:    r.answer = live && stored == ver;
      OP_WAS_REMOVED: r.answer = live && stored > ver;
      OP_GET_VERSION: r.answer = live;
      default: begin
        r.idx    = '0;
        r.ver    = '0;
        r.status = ST_OK;
      end
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [VER_W-1:0] ver);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    handle_index   <= idx;
    handle_version <= ver;
    do @(posedge clk_i); while (in_stall_o);
    handle_results_due.push_back(apply_handle_op(op, idx, ver));
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain_results;
    in_valid <= 1'b0;
    while (handle_results_due.size() > 0) @(posedge clk_i);
  endtask

  task automatic test_empty_table;
    send_word(OP_IS_VALID, '0, '0);
    send_word(OP_WAS_REMOVED, '1, '1);
    send_word(OP_GET_VERSION, '1, '0);
    send_word(OP_DESTROY, '0, '0);
    send_word(OP_DESTROY, '1, '1);
    send_word(OP_SPARE_LO, '1, '1);
    send_word(OP_SPARE_MID, '0, '1);
    send_word(OP_SPARE_HI, '1, '0);
  endtask

  task automatic test_basic_lifecycle;
    send_word(OP_CREATE, '1, '1);
    send_word(OP_CREATE, '0, '0);
    send_word(OP_CREATE, '0, '0);
    send_word(OP_IS_VALID, 10'd1, '0);
    send_word(OP_IS_VALID, 10'd1, '1);
    send_word(OP_WAS_REMOVED, 10'd1, '0);
    send_word(OP_DESTROY, 10'd1, 12'd5);
    send_word(OP_DESTROY, 10'd1, '0);
    send_word(OP_WAS_REMOVED, 10'd1, '0);
    send_word(OP_IS_VALID, 10'd1, '0);
    send_word(OP_GET_VERSION, 10'd1, '0);
    send_word(OP_GET_VERSION, 10'd3, '0);
    send_word(OP_DESTROY, 10'd2, '0);
    send_word(OP_CREATE, '0, '0);
    send_word(OP_CREATE, '0, '0);
    send_word(OP_CREATE, '0, '0);
  endtask

  task automatic test_random_mix(input int n_words);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VER_W-1:0] ver;
    for (int i = 0; i < n_words; i++) begin
      if (i % 64 == 0) steady = $urandom_range(0, 3) == 0;
      if (n_used > 0 && $urandom_range(0, 6) != 0) begin
        idx = IDX_W'($urandom_range(0, n_used - 1));
      end else begin
        idx = IDX_W'($urandom_range(0, CAPACITY - 1));
      end
      ver = ver_table[idx];
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 2))
          0:       ver = VER_W'($urandom_range(0, (1 << VER_W) - 1));
          1:       ver = VER_W'(ver - $urandom_range(1, 2));
          default: ver = ver + 1'b1;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_CREATE;
      else if (pick < 55) op = OP_DESTROY;
      else if (pick < 68) op = OP_IS_VALID;
      else if (pick < 80) op = OP_WAS_REMOVED;
      else if (pick < 92) op = OP_GET_VERSION;
      else if (pick < 96) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else begin
        op  = OP_W'($urandom_range(0, (1 << OP_W) - 1));
        idx = IDX_W'($urandom_range(0, CAPACITY - 1));
        ver = VER_W'($urandom_range(0, (1 << VER_W) - 1));
      end
      send_word(op, idx, ver);
    end
    steady = 1'b0;
  endtask

  initial begin
    out_stall <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      int hold;
      hold = steady ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (handle_results_due.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatches++;
      end else begin
        oldest_due = handle_results_due.pop_front();
        if (result_index_o !== oldest_due.idx) begin
          $error("result_index: expected %0d, got %0d", oldest_due.idx, result_index_o);
          mismatches++;
        end
        if (result_version_o !== oldest_due.ver) begin
          $error("result_version: expected %0d, got %0d", oldest_due.ver,
                 result_version_o);
          mismatches++;
        end
        if (answer_o !== oldest_due.answer) begin
          $error("answer: expected %0d, got %0d", oldest_due.answer, answer_o);
          mismatches++;
        end
        if (status_o !== oldest_due.status) begin
          $error("status: expected %0d, got %0d", oldest_due.status, status_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    in_valid       <= 1'b0;
    opcode         <= '0;
    handle_index   <= '0;
    handle_version <= '0;
    n_used     = 0;
    n_free     = 0;
    mismatches = 0;
    steady     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_basic_lifecycle();
    drain_results();
    test_random_mix(926);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
